FILE: hw/rtl/sqltok_pkg.sv
`timescale 1ns / 1ps
package sqltok_pkg;

    localparam int unsigned POSITION_BITS_DEF = 16;
    localparam int unsigned KEYWORD_CHARS_DEF = 6;
    localparam int unsigned LEN_W             = 16;
    localparam int unsigned KIND_W            = 5;
    localparam int unsigned MAX_TOK           = 3;
    localparam int unsigned QUEUE_DEPTH       = 4;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic [15:0]       token_start;
        logic [15:0]       token_length;
        logic              last_token;
    } t_out_item;

    // lexer modes
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_WORD   = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_STRING = 3'd3,
        MODE_LT     = 3'd4,
        MODE_GT     = 3'd5,
        MODE_BANG   = 3'd6
    } t_mode;

    // token kinds
    localparam logic [KIND_W-1:0] K_COMMA   = 5'd0;
    localparam logic [KIND_W-1:0] K_STAR    = 5'd1;
    localparam logic [KIND_W-1:0] K_LPAREN  = 5'd2;
    localparam logic [KIND_W-1:0] K_RPAREN  = 5'd3;
    localparam logic [KIND_W-1:0] K_PLUS    = 5'd4;
    localparam logic [KIND_W-1:0] K_MINUS   = 5'd5;
    localparam logic [KIND_W-1:0] K_SEMI    = 5'd6;
    localparam logic [KIND_W-1:0] K_EQ      = 5'd7;
    localparam logic [KIND_W-1:0] K_NE      = 5'd8;
    localparam logic [KIND_W-1:0] K_LE      = 5'd9;
    localparam logic [KIND_W-1:0] K_GE      = 5'd10;
    localparam logic [KIND_W-1:0] K_KEY0    = 5'd11;
    localparam logic [KIND_W-1:0] K_IDENT   = 5'd23;
    localparam logic [KIND_W-1:0] K_INT     = 5'd24;
    localparam logic [KIND_W-1:0] K_FLOAT   = 5'd25;
    localparam logic [KIND_W-1:0] K_STRING  = 5'd26;
    localparam logic [KIND_W-1:0] K_ILLEGAL = 5'd27;
    localparam logic [KIND_W-1:0] K_END     = 5'd28;

    // keyword table, left-aligned, zero padded to 6 chars
    localparam int unsigned NUM_KW = 12;
    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        "create", {"table", 8'h0}, "insert", {"into", 16'h0},
        "delete", {"drop", 16'h0}, "select", {"from", 16'h0},
        {"where", 8'h0}, {"and", 24'h0}, {"or", 32'h0}, {"not", 24'h0}
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd6, 3'd5, 3'd6, 3'd4, 3'd6, 3'd4, 3'd6, 3'd4, 3'd5, 3'd3, 3'd2, 3'd3
    };

    // one pending token handed from front to back
    typedef struct packed {
        logic              is_word;   // kind resolved by keyword match in back
        logic [KIND_W-1:0] kind;
        logic [15:0]       start;
        logic [LEN_W-1:0]  len;
        logic [47:0]       word;      // first six buffered chars
    } t_tok;

    // one queue entry: up to three tokens of one character
    typedef struct packed {
        logic [1:0]           count;
        t_tok [MAX_TOK-1:0]   toks;
    } t_batch;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
    endfunction

endpackage

FILE: hw/rtl/sqltok_front.sv
`timescale 1ns / 1ps
// Front end: per-character lexer state update, produces a batch of tokens.
module sqltok_front #(
    parameter int unsigned POSITION_BITS = 16,
    parameter int unsigned KEYWORD_CHARS = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  sqltok_pkg::t_in_item  i_item,
    output sqltok_pkg::t_batch    o_batch
);
    import sqltok_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [LEN_W-1:0]         LEN_MAX = '1;

    t_mode                    r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_begin, n_begin;
    logic [LEN_W-1:0]         r_count, n_count;
    logic [1:0]               r_dots, n_dots;
    logic [7:0]               r_wbuf [KEYWORD_CHARS];
    logic [7:0]               n_wbuf [KEYWORD_CHARS];
    logic [7:0]               r_prev, n_prev;

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pos   <= '0;
            r_begin <= '0;
            r_count <= '0;
            r_dots  <= '0;
            r_prev  <= '0;
            for (int i = 0; i < KEYWORD_CHARS; i++) r_wbuf[i] <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_begin <= n_begin;
            r_count <= n_count;
            r_dots  <= n_dots;
            r_prev  <= n_prev;
            for (int i = 0; i < KEYWORD_CHARS; i++) r_wbuf[i] <= n_wbuf[i];
        end
    end

    logic [7:0] c;
    logic       again;
    logic [LEN_W-1:0] cnt_inc;
    logic [POSITION_BITS-1:0] pos_inc;
    t_tok       tk;

    function automatic logic [47:0] pack_word(input logic [7:0] w [KEYWORD_CHARS]);
        logic [47:0] r;
        r = '0;
        for (int i = 0; i < 6; i++) r[47-8*i -: 8] = w[i];
        return r;
    endfunction

    function automatic logic [KIND_W-1:0] num_kind(input logic [1:0] d);
        return (d == 2'd0) ? K_INT : (d == 2'd1) ? K_FLOAT : K_ILLEGAL;
    endfunction

    always_comb begin
        c       = i_item.char_code;
        n_mode  = r_mode;
        n_begin = r_begin;
        n_count = r_count;
        n_dots  = r_dots;
        for (int i = 0; i < KEYWORD_CHARS; i++) n_wbuf[i] = r_wbuf[i];
        again   = 1'b0;
        cnt_inc = (r_count != LEN_MAX) ? r_count + 1'b1 : LEN_MAX;
        pos_inc = (r_pos != POS_MAX) ? r_pos + 1'b1 : POS_MAX;
        o_batch = '0;
        tk      = '0;

        // continue the current token
        case (r_mode)
            MODE_WORD: begin
                if (is_alpha(c) || is_digit(c) || c == "_") begin
                    for (int i = 0; i < KEYWORD_CHARS; i++)
                        if (r_count == LEN_W'(i)) n_wbuf[i] = to_lower(c);
                    n_count = cnt_inc;
                end else begin
                    tk = '{1'b1, K_IDENT, 16'(r_begin), r_count, pack_word(r_wbuf)};
                    o_batch.toks[o_batch.count] = tk;
                    o_batch.count = o_batch.count + 2'd1;
                    again = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (is_digit(c) || c == ".") begin
                    if (c == "." && r_dots != 2'd2) n_dots = r_dots + 2'd1;
                    n_count = cnt_inc;
                end else begin
                    tk = '{1'b0, num_kind(r_dots), 16'(r_begin), r_count, 48'h0};
                    o_batch.toks[o_batch.count] = tk;
                    o_batch.count = o_batch.count + 2'd1;
                    again = 1'b1;
                end
            end
            MODE_STRING: begin
                if (c == "'" && r_prev != "\\") begin
                    tk = '{1'b0, K_STRING, 16'(r_begin), r_count, 48'h0};
                    o_batch.toks[o_batch.count] = tk;
                    o_batch.count = o_batch.count + 2'd1;
                    n_mode = MODE_IDLE;
                end else begin
                    n_count = cnt_inc;
                end
            end
            MODE_LT, MODE_GT, MODE_BANG: begin
                if (c == "=") begin
                    tk = '{1'b0, (r_mode == MODE_LT) ? K_LE :
                           (r_mode == MODE_GT) ? K_GE : K_NE,
                           16'(r_begin), LEN_W'(2), 48'h0};
                    o_batch.toks[o_batch.count] = tk;
                    o_batch.count = o_batch.count + 2'd1;
                    n_mode = MODE_IDLE;
                end else if (c == ">" && r_mode == MODE_LT) begin
                    tk = '{1'b0, K_NE, 16'(r_begin), LEN_W'(2), 48'h0};
                    o_batch.toks[o_batch.count] = tk;
                    o_batch.count = o_batch.count + 2'd1;
                    n_mode = MODE_IDLE;
                end else begin
                    tk = '{1'b0, K_ILLEGAL, 16'(r_begin), LEN_W'(1), 48'h0};
                    o_batch.toks[o_batch.count] = tk;
                    o_batch.count = o_batch.count + 2'd1;
                    again = 1'b1;
                end
            end
            default: again = 1'b1;
        endcase

        // start a new token on this character
        if (again) begin
            n_mode = MODE_IDLE;
            tk = '{1'b0, K_ILLEGAL, 16'(r_pos), LEN_W'(1), 48'h0};
            if (is_space(c)) begin
                tk.kind = K_ILLEGAL;
            end else if (is_digit(c)) begin
                n_mode = MODE_NUMBER; n_begin = r_pos; n_count = LEN_W'(1); n_dots = '0;
            end else if (is_alpha(c)) begin
                n_mode = MODE_WORD; n_begin = r_pos; n_count = LEN_W'(1);
                // unused tail reads as zero so the keyword compare sees padding
                for (int i = 1; i < KEYWORD_CHARS; i++) n_wbuf[i] = '0;
                n_wbuf[0] = to_lower(c);
            end else if (c == "<") begin
                n_mode = MODE_LT; n_begin = r_pos;
            end else if (c == ">") begin
                n_mode = MODE_GT; n_begin = r_pos;
            end else if (c == "!") begin
                n_mode = MODE_BANG; n_begin = r_pos;
            end else if (c == "'") begin
                n_mode = MODE_STRING; n_begin = pos_inc; n_count = '0;
            end else begin
                case (c)
                    ",":     tk.kind = K_COMMA;
                    "*":     tk.kind = K_STAR;
                    "(":     tk.kind = K_LPAREN;
                    ")":     tk.kind = K_RPAREN;
                    "+":     tk.kind = K_PLUS;
                    "-":     tk.kind = K_MINUS;
                    ";":     tk.kind = K_SEMI;
                    "=":     tk.kind = K_EQ;
                    default: tk.kind = K_ILLEGAL;
                endcase
                o_batch.toks[o_batch.count] = tk;
                o_batch.count = o_batch.count + 2'd1;
            end
        end
        n_prev = c;
        n_pos  = pos_inc;

        // flush on end of text
        if (i_item.end_of_text) begin
            case (n_mode)
                MODE_WORD: begin
                    tk = '{1'b1, K_IDENT, 16'(n_begin), n_count, pack_word(n_wbuf)};
                    o_batch.toks[o_batch.count] = tk;
                    o_batch.count = o_batch.count + 2'd1;
                end
                MODE_NUMBER: begin
                    tk = '{1'b0, num_kind(n_dots), 16'(n_begin), n_count, 48'h0};
                    o_batch.toks[o_batch.count] = tk;
                    o_batch.count = o_batch.count + 2'd1;
                end
                MODE_STRING: begin
                    tk = '{1'b0, K_ILLEGAL, 16'(n_begin), n_count, 48'h0};
                    o_batch.toks[o_batch.count] = tk;
                    o_batch.count = o_batch.count + 2'd1;
                end
                MODE_LT, MODE_GT, MODE_BANG: begin
                    tk = '{1'b0, K_ILLEGAL, 16'(n_begin), LEN_W'(1), 48'h0};
                    o_batch.toks[o_batch.count] = tk;
                    o_batch.count = o_batch.count + 2'd1;
                end
                default: ;
            endcase
            // END marker: kind END with zero length, flagged by is_word=0
            tk = '{1'b0, K_END, 16'(n_pos), LEN_W'(0), 48'h0};
            o_batch.toks[o_batch.count] = tk;
            o_batch.count = o_batch.count + 2'd1;
            n_mode  = MODE_IDLE;
            n_pos   = '0;
            n_begin = '0;
            n_count = '0;
            n_dots  = '0;
            n_prev  = '0;
            for (int i = 0; i < KEYWORD_CHARS; i++) n_wbuf[i] = '0;
        end
    end

endmodule

FILE: hw/rtl/sqltok_back.sv
`timescale 1ns / 1ps
// Back end: pops batches, resolves keywords, serializes tokens to output.
module sqltok_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  sqltok_pkg::t_batch    i_q_batch,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sqltok_pkg::t_out_item o_data
);
    import sqltok_pkg::*;

    logic [1:0]      r_idx, n_idx;
    logic            r_valid, n_valid;
    t_out_item       r_data, n_data;
    t_tok            cur;
    logic [KIND_W-1:0] kind;
    logic            load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

    // keyword match on the selected token
    always_comb begin
        cur  = i_q_batch.toks[r_idx];
        kind = cur.kind;
        if (cur.is_word) begin
            for (int k = NUM_KW - 1; k >= 0; k--) begin
                if (cur.len == LEN_W'(KW_LEN[k]) && cur.word == KW_TEXT[k])
                    kind = K_KEY0 + KIND_W'(k);
            end
        end
    end

    // load output register when empty or being drained
    always_comb begin
        load    = i_q_valid && (!r_valid || i_ready);
        n_valid = r_valid && !i_ready;
        n_idx   = r_idx;
        n_data  = r_data;
        o_q_pop = 1'b0;
        if (load) begin
            n_valid = 1'b1;
            n_data  = '{kind, cur.start, cur.len, (cur.kind == K_END) && !cur.is_word};
            if (r_idx + 2'd1 >= i_q_batch.count) begin
                n_idx   = '0;
                o_q_pop = 1'b1;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: hw/rtl/sqltok_fifo.sv
`timescale 1ns / 1ps
// Small batch queue between front and back.
module sqltok_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sqltok_pkg::t_batch i_batch,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_pop,
    output sqltok_pkg::t_batch o_batch
);
    import sqltok_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    t_batch          r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [AW:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
        if (i_push) r_mem[r_wr] <= i_batch;
    end

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_batch = r_mem[r_rd];

endmodule

FILE: hw/rtl/sql_token_lexer.sv
`timescale 1ns / 1ps
// SQL lexer. Input channel: one character per transfer (i_in_valid/o_in_ready,
// payload char_code and end_of_text). Output channel: one token per transfer
// (o_out_valid/i_out_ready: kind, start, length, last_token flag).
// The front end updates lexer state in the cycle a character is taken and
// pushes the 0..3 tokens it produces as one batch into a 4-entry queue.
// The back end resolves keywords and drains one token per cycle, while the
// receiver is ready, into an output register; a token travels through the
// queue and that register. Characters are taken one per cycle while the queue has room;
// characters that make no token cost no output slot. Sustained rate is one
// character per cycle, limited by one token per cycle on the output.
// Reset (synchronous, active low) returns to the start of a statement with
// empty queue. A stalled receiver holds the output register; the queue
// fills and o_in_ready drops until room returns. After the END token the
// next character is offset 0 of a new statement.
module sql_token_lexer #(
    parameter int unsigned POSITION_BITS = sqltok_pkg::POSITION_BITS_DEF,
    parameter int unsigned KEYWORD_CHARS = sqltok_pkg::KEYWORD_CHARS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sqltok_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sqltok_pkg::t_out_item o_out_data
);
    import sqltok_pkg::*;

    logic   step, full, q_valid, q_pop;
    t_batch f_batch, q_batch;

    assign o_in_ready = !full;
    assign step       = i_in_valid && !full;

    sqltok_front #(
        .POSITION_BITS(POSITION_BITS),
        .KEYWORD_CHARS(KEYWORD_CHARS)
    ) u_front (
        .i_clk, .i_rst_n, .i_step(step), .i_item(i_in_data), .o_batch(f_batch)
    );

    sqltok_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk, .i_rst_n,
        .i_push(step && f_batch.count != 2'd0), .i_batch(f_batch),
        .o_full(full), .o_valid(q_valid), .i_pop(q_pop), .o_batch(q_batch)
    );

    sqltok_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_batch(q_batch), .o_q_pop(q_pop),
        .o_valid(o_out_valid), .i_ready(i_out_ready), .o_data(o_out_data)
    );

endmodule

FILE: hw/rtl/sqltok_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the lexer.
module sqltok_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input sqltok_pkg::t_in_item  i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input sqltok_pkg::t_out_item o_out_data
);
    import sqltok_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed under stall");

    // last_token only with END kind
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last_token == (o_out_data.token_kind == K_END)))
        else $error("last flag mismatch");

    // END has zero length
    a_endlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.last_token |-> o_out_data.token_length == '0)
        else $error("END length nonzero");

    // kinds stay in range
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.token_kind <= K_END)
        else $error("bad kind");

    // out of reset the lexer accepts input
    a_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("not ready after reset");

endmodule

bind sql_token_lexer sqltok_checker u_checker (.*);
